### src/ctgu_pkg.sv
// Shared constants, types and the per-word gate function of the tableau gate update block.
`timescale 1ns / 1ps
package ctgu_pkg;

   localparam int MAX_QUBITS    = 256;
   localparam int WORD_BITS     = 64;
   localparam int WORDS_PER_ROW = (MAX_QUBITS + WORD_BITS - 1) / WORD_BITS;
   localparam int ROW_CELLS     = MAX_QUBITS * WORDS_PER_ROW;
   localparam int QUBIT_W       = 8;
   localparam int CMD_W         = 4;
   localparam int ACT_W         = 9;
   localparam int WIDX_W        = $clog2(WORDS_PER_ROW);
   localparam int ADDR_W        = $clog2(ROW_CELLS);
   localparam int BIT_W         = $clog2(WORD_BITS);
   localparam int NW_W          = ACT_W + 1;
   localparam int ACTIVE_RESET  = 256;

   typedef enum logic [CMD_W-1:0] {
      CMD_ZCX    = 4'd0,
      CMD_ZCY    = 4'd1,
      CMD_ZCZ    = 4'd2,
      CMD_SWAP   = 4'd3,
      CMD_H_XY   = 4'd4,
      CMD_H_YZ   = 4'd5,
      CMD_S      = 4'd6,
      CMD_H_XZ   = 4'd7,
      CMD_X      = 4'd8,
      CMD_READ_X = 4'd9
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_SAME  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_REPORT,
      KIND_QUERY,
      KIND_GATE_ONE,
      KIND_GATE_TWO
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_UPDATE,
      ST_WRITE_B,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic rd_en;
      logic rd_next;
      logic word_inc;
      logic write_a;
      logic write_b;
      logic emit_word;
      logic emit_report;
   } ctrl_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     last_word;
      logic     clear_done;
   } dp_status_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] cx;
      logic [WORD_BITS-1:0] cz;
      logic [WORD_BITS-1:0] tx;
      logic [WORD_BITS-1:0] tz;
      logic [WORD_BITS-1:0] s;
   } gate_word_type;

   // One word of one half: control row (cx, cz), target row (tx, tz), sign word s.
   function automatic gate_word_type gate_word(input logic [CMD_W-1:0]     op,
                                               input logic [WORD_BITS-1:0] cx,
                                               input logic [WORD_BITS-1:0] cz,
                                               input logic [WORD_BITS-1:0] tx,
                                               input logic [WORD_BITS-1:0] tz,
                                               input logic [WORD_BITS-1:0] s);
      gate_word_type r;
      logic [WORD_BITS-1:0] cz1;
      r   = '{cx: cx, cz: cz, tx: tx, tz: tz, s: s};
      cz1 = cz ^ tx;
      case (op)
         CMD_ZCX: begin
            r.s  = s ^ (~(cz ^ tx) & cx & tz);
            r.cz = cz ^ tz;
            r.tx = tx ^ cx;
         end
         CMD_ZCY: begin
            r.s  = s ^ (cx & cz1 & (tx ^ tz));
            r.cz = cz1 ^ tz;
            r.tx = tx ^ cx;
            r.tz = tz ^ cx;
         end
         CMD_ZCZ: begin
            r.s  = s ^ (cx & tx & (cz ^ tz));
            r.cz = cz ^ tx;
            r.tz = tz ^ cx;
         end
         CMD_SWAP: begin
            r.cx = tx;
            r.tx = cx;
            r.cz = tz;
            r.tz = cz;
         end
         CMD_H_XY: begin
            r.s  = s ^ (~cx & cz);
            r.cz = cz ^ cx;
         end
         CMD_H_YZ: begin
            r.s  = s ^ (~cz & cx);
            r.cx = cx ^ cz;
         end
         CMD_S: begin
            r.s  = s ^ (cx & cz);
            r.cz = cz ^ cx;
         end
         CMD_H_XZ: begin
            r.cx = cz;
            r.cz = cx;
            r.s  = s ^ (cx & cz);
         end
         default: begin
            r.s = s ^ cz;
         end
      endcase
      return r;
   endfunction

endpackage

### src/ctgu_ctrl.sv
// Sequencer for clearing, gate read-modify-write passes, queries and status items.
`timescale 1ns / 1ps
module ctgu_ctrl
   import ctgu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  dp_status_type stat,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.kind == KIND_REPORT) begin
               state_in = ST_REPORT;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_UPDATE;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (stat.kind == KIND_QUERY) begin
               cmd.emit_word = 1'b1;
               if (stat.last_word) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.rd_en    = 1'b1;
                  cmd.rd_next  = 1'b1;
                  cmd.word_inc = 1'b1;
               end
            end else if (stat.kind == KIND_GATE_TWO) begin
               cmd.write_a = 1'b1;
               state_in    = ST_WRITE_B;
            end else begin
               cmd.write_a = 1'b1;
               if (stat.last_word) begin
                  state_in = ST_REPORT;
               end else begin
                  cmd.rd_en    = 1'b1;
                  cmd.rd_next  = 1'b1;
                  cmd.word_inc = 1'b1;
               end
            end
         end
         ST_WRITE_B: begin
            cmd.write_b = 1'b1;
            if (stat.last_word) begin
               state_in = ST_REPORT;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.rd_next  = 1'b1;
               cmd.word_inc = 1'b1;
               state_in     = ST_UPDATE;
            end
         end
         ST_REPORT: begin
            cmd.emit_report = 1'b1;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### src/ctgu_datapath.sv
// Tableau row memories, sign words, per-word gate logic and result registers.
`timescale 1ns / 1ps
module ctgu_datapath
   import ctgu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         cmd,
   output dp_status_type        stat,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [QUBIT_W-1:0]   req_qubit_a,
   input  logic [QUBIT_W-1:0]   req_qubit_b,
   input  logic [ACT_W-1:0]     active_qubits,
   output logic                 rsp_strobe,
   output logic [1:0]           rsp_status,
   output logic [WORD_BITS-1:0] rsp_x_word,
   output logic [WORD_BITS-1:0] rsp_z_word,
   output logic [WIDX_W-1:0]    rsp_word_index,
   output logic                 rsp_last
);

   logic [CMD_W-1:0]     op_ff;
   logic [QUBIT_W-1:0]   qa_ff, qb_ff;
   logic [WIDX_W-1:0]    word_ff;
   logic [ADDR_W-1:0]    clr_ff;

   logic [ACT_W-1:0]     act;
   logic [NW_W-1:0]      nw;
   logic [WIDX_W-1:0]    nw_m1;
   logic                 two_q, known, range_bad, same_q;
   status_type           report_status;

   logic [WIDX_W-1:0]    rd_word;
   logic [ADDR_W-1:0]    rd_addr_a, rd_addr_b, wr_addr;
   logic                 wr_en;
   logic [QUBIT_W-1:0]   clr_q;
   logic [WORD_BITS-1:0] clr_ident;

   logic [ACT_W-1:0]     rem;
   logic [WORD_BITS-1:0] mask;

   logic [WORD_BITS-1:0] xs_ra [2];
   logic [WORD_BITS-1:0] xs_rb [2];
   logic [WORD_BITS-1:0] zs_ra [2];
   logic [WORD_BITS-1:0] zs_rb [2];
   logic [WORD_BITS-1:0] hold_tx_ff [2];
   logic [WORD_BITS-1:0] hold_tz_ff [2];
   logic [WORD_BITS-1:0] xs_wdata [2];
   logic [WORD_BITS-1:0] zs_wdata [2];
   logic [WORD_BITS-1:0] sign_ff [2][WORDS_PER_ROW];
   gate_word_type        gres [2];

   logic                 strobe_ff;
   logic [1:0]           status_ff;
   logic [WORD_BITS-1:0] xw_ff, zw_ff;
   logic [WIDX_W-1:0]    widx_ff;
   logic                 last_ff;

   // command decode and range checks
   always_comb begin
      act       = (active_qubits > ACT_W'(MAX_QUBITS)) ? ACT_W'(MAX_QUBITS) : active_qubits;
      nw        = (NW_W'(act) + NW_W'(WORD_BITS - 1)) >> BIT_W;
      nw_m1     = WIDX_W'(nw - NW_W'(1));
      two_q     = op_ff <= CMD_SWAP;
      known     = op_ff <= CMD_READ_X;
      range_bad = ({1'b0, qa_ff} >= act) || (two_q && ({1'b0, qb_ff} >= act));
      same_q    = two_q && (qa_ff == qb_ff);
      if (!known) begin
         report_status = STATUS_OK;
      end else if (range_bad) begin
         report_status = STATUS_RANGE;
      end else if (same_q) begin
         report_status = STATUS_SAME;
      end else begin
         report_status = STATUS_OK;
      end
      if (!known || range_bad || same_q) begin
         stat.kind = KIND_REPORT;
      end else if (op_ff == CMD_READ_X) begin
         stat.kind = KIND_QUERY;
      end else if (two_q) begin
         stat.kind = KIND_GATE_TWO;
      end else begin
         stat.kind = KIND_GATE_ONE;
      end
      stat.last_word  = word_ff == nw_m1;
      stat.clear_done = clr_ff == {ADDR_W{1'b1}};
   end

   // addressing; clear sweep writes the identity pattern row by row
   always_comb begin
      rd_word   = cmd.rd_next ? word_ff + 1'b1 : word_ff;
      rd_addr_a = {qa_ff, rd_word};
      rd_addr_b = {qb_ff, rd_word};
      if (cmd.clear) begin
         wr_addr = clr_ff;
      end else if (cmd.write_b) begin
         wr_addr = {qb_ff, word_ff};
      end else begin
         wr_addr = {qa_ff, word_ff};
      end
      wr_en     = cmd.clear | cmd.write_a | cmd.write_b;
      clr_q     = clr_ff[ADDR_W-1:WIDX_W];
      clr_ident = ((clr_q >> BIT_W) == QUBIT_W'(clr_ff[WIDX_W-1:0]))
                  ? (WORD_BITS'(1) << clr_q[BIT_W-1:0]) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_command;
         qa_ff   <= req_qubit_a;
         qb_ff   <= req_qubit_b;
         word_ff <= '0;
      end else if (cmd.word_inc) begin
         word_ff <= word_ff + 1'b1;
      end
   end

   for (genvar h = 0; h < 2; h++) begin : g_half
      logic [WORD_BITS-1:0] xs_mem [ROW_CELLS];
      logic [WORD_BITS-1:0] zs_mem [ROW_CELLS];

      assign gres[h] = gate_word(op_ff, xs_ra[h], zs_ra[h], xs_rb[h], zs_rb[h],
                                 sign_ff[h][word_ff]);

      // half 0 resets x bits to identity, half 1 resets z bits to identity
      always_comb begin
         if (cmd.clear) begin
            xs_wdata[h] = (h == 0) ? clr_ident : '0;
            zs_wdata[h] = (h == 1) ? clr_ident : '0;
         end else if (cmd.write_b) begin
            xs_wdata[h] = hold_tx_ff[h];
            zs_wdata[h] = hold_tz_ff[h];
         end else begin
            xs_wdata[h] = gres[h].cx;
            zs_wdata[h] = gres[h].cz;
         end
      end

      always_ff @(posedge clock) begin
         if (wr_en) begin
            xs_mem[wr_addr] <= xs_wdata[h];
            zs_mem[wr_addr] <= zs_wdata[h];
         end
         if (cmd.rd_en) begin
            xs_ra[h] <= xs_mem[rd_addr_a];
            xs_rb[h] <= xs_mem[rd_addr_b];
            zs_ra[h] <= zs_mem[rd_addr_a];
            zs_rb[h] <= zs_mem[rd_addr_b];
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.write_a) begin
            hold_tx_ff[h] <= gres[h].tx;
            hold_tz_ff[h] <= gres[h].tz;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            for (int w = 0; w < WORDS_PER_ROW; w++) begin
               sign_ff[h][w] <= '0;
            end
         end else if (cmd.write_a) begin
            sign_ff[h][word_ff] <= gres[h].s;
         end
      end
   end

   // query mask: qubit positions at or above the active count read as zero
   always_comb begin
      rem  = act - ACT_W'({word_ff, BIT_W'(0)});
      mask = (rem < ACT_W'(WORD_BITS)) ? ~({WORD_BITS{1'b1}} << rem[BIT_W-1:0])
                                       : {WORD_BITS{1'b1}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit_word | cmd.emit_report;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_word) begin
         status_ff <= STATUS_OK;
         xw_ff     <= zs_ra[1] & mask;
         zw_ff     <= zs_ra[0] & mask;
         widx_ff   <= word_ff;
         last_ff   <= stat.last_word;
      end else if (cmd.emit_report) begin
         status_ff <= report_status;
         xw_ff     <= '0;
         zw_ff     <= '0;
         widx_ff   <= '0;
         last_ff   <= 1'b1;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_status     = status_ff;
   assign rsp_x_word     = xw_ff;
   assign rsp_z_word     = zw_ff;
   assign rsp_word_index = widx_ff;
   assign rsp_last       = last_ff;

endmodule

### src/clifford_tableau_gate_update_top.sv
// Top level of the transposed stabilizer tableau gate update block with its register port.
`timescale 1ns / 1ps
// Items: a status-only item gives one reply; a query gives its words one a cycle in order,
//   rsp_last on the last; a gate gives one status reply once all its words are written.
// A two-qubit gate writes each word twice on the single write port; words =
//   ceil(active_qubits/64) with the count clamped to 256, four at full size. One item
//   at a time: busy stays high until the item is done. Reset: a clearing pass loads the
//   identity tableau; busy stays high meanwhile. Results cannot be stalled: rsp_strobe marks each.
module clifford_tableau_gate_update_top
   import ctgu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // command channel
   input  logic                 start,
   output logic                 busy,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [QUBIT_W-1:0]   req_qubit_a,
   input  logic [QUBIT_W-1:0]   req_qubit_b,
   // result channel
   output logic                 rsp_strobe,
   output logic [1:0]           rsp_status,
   output logic [WORD_BITS-1:0] rsp_x_word,
   output logic [WORD_BITS-1:0] rsp_z_word,
   output logic [WIDX_W-1:0]    rsp_word_index,
   output logic                 rsp_last,
   // register port
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   ctrl_cmd_type     cmd;
   dp_status_type    stat;
   logic [ACT_W-1:0] active_qubits_ff;
   logic             csr_hit;

   // Single register: active qubit count, decoded from address bit 2 only (byte addresses 0 to 3).
   assign csr_hit    = csr_paddr[2] == 1'b0;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? 32'(active_qubits_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_qubits_ff <= ACT_W'(ACTIVE_RESET);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         active_qubits_ff <= csr_pwdata[ACT_W-1:0];
      end
   end

   // Controller: one item at a time, walks the words of the addressed rows.
   ctgu_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Datapath: four row memories (x/z bits of each half), sign words, output registers.
   ctgu_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_command    (req_command),
      .req_qubit_a    (req_qubit_a),
      .req_qubit_b    (req_qubit_b),
      .active_qubits  (active_qubits_ff),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_x_word     (rsp_x_word),
      .rsp_z_word     (rsp_z_word),
      .rsp_word_index (rsp_word_index),
      .rsp_last       (rsp_last)
   );

endmodule

### bench/tableau_reply_checker.sv
// Checker for the tableau gate update block: shadow tableau, awaited replies, comparison.
`timescale 1ns / 1ps
module tableau_reply_checker
   import ctgu_pkg::*;
#(
   parameter logic [2:0] ACTIVE_ADDR = 3'd0
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [QUBIT_W-1:0]   req_qubit_a,
   input  logic [QUBIT_W-1:0]   req_qubit_b,
   input  logic                 rsp_strobe,
   input  logic [1:0]           rsp_status,
   input  logic [WORD_BITS-1:0] rsp_x_word,
   input  logic [WORD_BITS-1:0] rsp_z_word,
   input  logic [WIDX_W-1:0]    rsp_word_index,
   input  logic                 rsp_last,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   input  logic [31:0]          csr_prdata,
   input  logic                 csr_pready,
   output int                   mismatches,
   output int                   outstanding
);

   typedef struct packed {
      logic [1:0]           status;
      logic [WORD_BITS-1:0] x_word;
      logic [WORD_BITS-1:0] z_word;
      logic [WIDX_W-1:0]    word_index;
      logic                 last;
   } tableau_reply_t;

   // half 0 is the X half, half 1 the Z half
   logic [WORD_BITS-1:0] xbits [0:1][0:MAX_QUBITS-1][0:WORDS_PER_ROW-1];
   logic [WORD_BITS-1:0] zbits [0:1][0:MAX_QUBITS-1][0:WORDS_PER_ROW-1];
   logic [WORD_BITS-1:0] signs [0:1][0:WORDS_PER_ROW-1];
   logic [ACT_W-1:0]     active_shadow;
   tableau_reply_t       awaited_replies [$];
   tableau_reply_t       oldest;
   int                   fault_total = 0;

   task automatic load_identity();
      int h, q, w;
      for (h = 0; h < 2; h++) begin
         for (w = 0; w < WORDS_PER_ROW; w++) signs[h][w] = '0;
         for (q = 0; q < MAX_QUBITS; q++) begin
            for (w = 0; w < WORDS_PER_ROW; w++) begin
               xbits[h][q][w] = '0;
               zbits[h][q][w] = '0;
            end
         end
      end
      for (q = 0; q < MAX_QUBITS; q++) begin
         xbits[0][q][q / WORD_BITS] = 64'd1 << (q % WORD_BITS);
         zbits[1][q][q / WORD_BITS] = 64'd1 << (q % WORD_BITS);
      end
      active_shadow = ACT_W'(ACTIVE_RESET);
   endtask

   // one word of one half under a gate; tx/tz are zero for one-qubit gates
   task automatic conjugate_word(input logic [CMD_W-1:0] op,
                                 inout logic [WORD_BITS-1:0] cx,
                                 inout logic [WORD_BITS-1:0] cz,
                                 inout logic [WORD_BITS-1:0] tx,
                                 inout logic [WORD_BITS-1:0] tz,
                                 inout logic [WORD_BITS-1:0] sg);
      logic [WORD_BITS-1:0] held;
      case (op)
         CMD_ZCX: begin
            sg = sg ^ (~(cz ^ tx) & cx & tz);
            cz = cz ^ tz;
            tx = tx ^ cx;
         end
         CMD_ZCY: begin
            cz = cz ^ tx;
            sg = sg ^ (cx & cz & (tx ^ tz));
            cz = cz ^ tz;
            tx = tx ^ cx;
            tz = tz ^ cx;
         end
         CMD_ZCZ: begin
            sg = sg ^ (cx & tx & (cz ^ tz));
            cz = cz ^ tx;
            tz = tz ^ cx;
         end
         CMD_SWAP: begin
            held = cx; cx = tx; tx = held;
            held = cz; cz = tz; tz = held;
         end
         CMD_H_XY: begin
            sg = sg ^ (~cx & cz);
            cz = cz ^ cx;
         end
         CMD_H_YZ: begin
            sg = sg ^ (~cz & cx);
            cx = cx ^ cz;
         end
         CMD_S: begin
            sg = sg ^ (cx & cz);
            cz = cz ^ cx;
         end
         CMD_H_XZ: begin
            held = cx; cx = cz; cz = held;
            sg = sg ^ (cx & cz);
         end
         default: begin
            sg = sg ^ cz;
         end
      endcase
   endtask

   // updates the shadow tableau for one accepted item and queues its replies
   task automatic advance_tableau(input logic [CMD_W-1:0]   op,
                                  input logic [QUBIT_W-1:0] qa,
                                  input logic [QUBIT_W-1:0] qb);
      int eff, nw, lo, h, w;
      logic two;
      logic [WORD_BITS-1:0] cx, cz, tx, tz, sg, keep;
      tableau_reply_t r;
      eff  = (active_shadow > MAX_QUBITS) ? MAX_QUBITS : active_shadow;
      nw   = (eff + WORD_BITS - 1) / WORD_BITS;
      two  = (op <= CMD_SWAP);
      r    = '0;
      r.last = 1'b1;
      if (op > CMD_READ_X) begin
         r.status = STATUS_OK;
         awaited_replies.push_back(r);
      end else if (qa >= eff || (two && qb >= eff)) begin
         r.status = STATUS_RANGE;
         awaited_replies.push_back(r);
      end else if (two && qa == qb) begin
         r.status = STATUS_SAME;
         awaited_replies.push_back(r);
      end else if (op == CMD_READ_X) begin
         for (w = 0; w < nw; w++) begin
            lo   = w * WORD_BITS;
            keep = (eff - lo < WORD_BITS) ? ((64'd1 << (eff - lo)) - 64'd1) : '1;
            r.status     = STATUS_OK;
            r.x_word     = zbits[1][qa][w] & keep;
            r.z_word     = zbits[0][qa][w] & keep;
            r.word_index = WIDX_W'(w);
            r.last       = (w + 1 == nw);
            awaited_replies.push_back(r);
         end
      end else begin
         for (h = 0; h < 2; h++) begin
            for (w = 0; w < nw; w++) begin
               cx = xbits[h][qa][w];
               cz = zbits[h][qa][w];
               sg = signs[h][w];
               tx = two ? xbits[h][qb][w] : '0;
               tz = two ? zbits[h][qb][w] : '0;
               conjugate_word(op, cx, cz, tx, tz, sg);
               xbits[h][qa][w] = cx;
               zbits[h][qa][w] = cz;
               signs[h][w]     = sg;
               if (two) begin
                  xbits[h][qb][w] = tx;
                  zbits[h][qb][w] = tz;
               end
            end
         end
         r.status = STATUS_OK;
         awaited_replies.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         load_identity();
         awaited_replies.delete();
      end else begin
         // a reply never belongs to an item taken at the same edge
         if (rsp_strobe) begin
            if (awaited_replies.size() == 0) begin
               fault_total++;
               if (fault_total <= 10)
                  $display("unexpected reply: status %0d x %h z %h word %0d last %0d",
                           rsp_status, rsp_x_word, rsp_z_word, rsp_word_index, rsp_last);
            end else begin
               oldest = awaited_replies.pop_front();
               if (rsp_status !== oldest.status || rsp_x_word !== oldest.x_word ||
                   rsp_z_word !== oldest.z_word || rsp_word_index !== oldest.word_index ||
                   rsp_last !== oldest.last) begin
                  fault_total++;
                  if (fault_total <= 10)
                     $display({"reply mismatch: got status %0d x %h z %h word %0d last %0d",
                               " / wanted status %0d x %h z %h word %0d last %0d"},
                              rsp_status, rsp_x_word, rsp_z_word, rsp_word_index, rsp_last,
                              oldest.status, oldest.x_word, oldest.z_word,
                              oldest.word_index, oldest.last);
               end
            end
         end
         if (csr_psel && csr_penable && csr_pready && csr_paddr == ACTIVE_ADDR) begin
            if (csr_pwrite) begin
               active_shadow = csr_pwdata[ACT_W-1:0];
            end else if (csr_prdata !== {{(32-ACT_W){1'b0}}, active_shadow}) begin
               fault_total++;
               if (fault_total <= 10)
                  $display("register read mismatch: got %h wanted %h",
                           csr_prdata, active_shadow);
            end
         end
         if (start && !busy)
            advance_tableau(req_command, req_qubit_a, req_qubit_b);
      end
      outstanding <= awaited_replies.size();
      mismatches  <= fault_total;
   end

endmodule

### bench/clifford_tableau_gate_update_top_tb.sv
// Testbench top for the tableau gate update block: stimulus, register writes and verdict.
`timescale 1ns / 1ps
module clifford_tableau_gate_update_top_tb;
   import ctgu_pkg::*;

   // active_qubits is the only register, at byte address zero
   localparam logic [2:0]       ACTIVE_ADDR     = 3'd0;
   // commands with no meaning: the block answers them with a bare ok
   localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 4'd10;
   localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 4'd15;
   localparam int               IDLE_PERCENT    = 32;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 start       = 1'b0;
   logic [CMD_W-1:0]     req_command = '0;
   logic [QUBIT_W-1:0]   req_qubit_a = '0;
   logic [QUBIT_W-1:0]   req_qubit_b = '0;
   logic                 csr_psel    = 1'b0;
   logic                 csr_penable = 1'b0;
   logic                 csr_pwrite  = 1'b0;
   logic [2:0]           csr_paddr   = '0;
   logic [31:0]          csr_pwdata  = '0;
   logic                 busy;
   logic                 rsp_strobe;
   logic [1:0]           rsp_status;
   logic [WORD_BITS-1:0] rsp_x_word;
   logic [WORD_BITS-1:0] rsp_z_word;
   logic [WIDX_W-1:0]    rsp_word_index;
   logic                 rsp_last;
   logic [31:0]          csr_prdata;
   logic                 csr_pready;

   int fault_count;
   int replies_due;
   int act_size;     // last value written to active_qubits, unclamped
   bit gaps_on;      // sender idles at random when set

   always #1 clock = ~clock;

   clifford_tableau_gate_update_top u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_qubit_a    (req_qubit_a),
      .req_qubit_b    (req_qubit_b),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_x_word     (rsp_x_word),
      .rsp_z_word     (rsp_z_word),
      .rsp_word_index (rsp_word_index),
      .rsp_last       (rsp_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   tableau_reply_checker #(.ACTIVE_ADDR(ACTIVE_ADDR)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_qubit_a    (req_qubit_a),
      .req_qubit_b    (req_qubit_b),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_x_word     (rsp_x_word),
      .rsp_z_word     (rsp_z_word),
      .rsp_word_index (rsp_word_index),
      .rsp_last       (rsp_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .mismatches     (fault_count),
      .outstanding    (replies_due)
   );

   // Offers one item and returns at the edge that takes it. start is only touched
   // once per edge: it drops for a gap, or stays high straight into the next item.
   task automatic send_command(input logic [CMD_W-1:0]   op,
                               input logic [QUBIT_W-1:0] qa,
                               input logic [QUBIT_W-1:0] qb);
      if (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
         start <= 1'b0;
         repeat ($urandom_range(10, 1)) @(posedge clock);
      end
      start       <= 1'b1;
      req_command <= op;
      req_qubit_a <= qa;
      req_qubit_b <= qb;
      do @(posedge clock); while (busy);
   endtask

   // Holds the sender off until every awaited reply is in and the block is idle;
   // the tail then idles further before any register access.
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (busy || replies_due != 0);
      repeat (4) @(posedge clock);
   endtask

   // Setup cycle then access cycle; opens with an edge so psel never toggles twice
   // within one step when two accesses follow each other.
   task automatic csr_access(input logic wr, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= ACTIVE_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Only called with the block settled; the read-back is checked by the checker.
   task automatic set_active(input int value);
      csr_access(1'b1, value);
      csr_access(1'b0, '0);
      act_size = value;
   endtask

   // Mostly well-formed gates and queries on live qubits, so the tableau drifts far
   // from identity; a tenth or so is noise: spare commands, stray indices, same qubit.
   task automatic send_random(input int count);
      int n, eff, roll;
      logic [CMD_W-1:0]   op;
      logic [QUBIT_W-1:0] qa, qb;
      for (n = 0; n < count; n++) begin
         eff  = (act_size > MAX_QUBITS) ? MAX_QUBITS : act_size;
         roll = $urandom_range(99);
         qa   = QUBIT_W'($urandom_range(255));
         qb   = QUBIT_W'($urandom_range(255));
         if (roll < 4) begin
            op = CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
         end else if (roll < 8) begin
            op = CMD_W'($urandom_range(CMD_READ_X));
         end else if (roll < 11) begin
            op = CMD_W'($urandom_range(CMD_SWAP));
            qb = qa;
         end else begin
            if (eff > 0) qa = QUBIT_W'($urandom_range(eff - 1));
            if (eff > 1) qb = QUBIT_W'((qa + 1 + $urandom_range(eff - 2)) % eff);
            op = (roll < 30) ? CMD_READ_X : CMD_W'($urandom_range(CMD_X));
         end
         send_command(op, qa, qb);
      end
   endtask

   initial begin
      act_size = ACTIVE_RESET;
      gaps_on  = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // clearing pass: busy stays high until the identity tableau is loaded
      settle();

      // directed, full size: every gate, several on the edge qubits, queries, same qubit
      send_command(CMD_ZCX,    8'd0,   8'd255);
      send_command(CMD_ZCY,    8'd255, 8'd1);
      send_command(CMD_ZCZ,    8'd0,   8'd1);
      send_command(CMD_SWAP,   8'd1,   8'd200);
      send_command(CMD_H_XY,   8'd0,   8'd0);
      send_command(CMD_H_YZ,   8'd255, 8'd0);
      send_command(CMD_S,      8'd0,   8'd9);
      send_command(CMD_H_XZ,   8'd200, 8'd255);
      send_command(CMD_X,      8'd64,  8'd0);
      send_command(CMD_READ_X, 8'd0,   8'd0);
      send_command(CMD_READ_X, 8'd255, 8'd0);
      send_command(CMD_ZCX,    8'd7,   8'd7);
      send_command(CMD_SPARE_LAST, 8'd255, 8'd255);
      send_command(CMD_SWAP,   8'd255, 8'd0);
      send_command(CMD_READ_X, 8'd200, 8'd0);

      // directed, partial last word: stray indices, ignored target, masked query
      settle();
      set_active(200);
      send_command(CMD_READ_X, 8'd199, 8'd0);
      send_command(CMD_H_XY,   8'd255, 8'd0);
      send_command(CMD_ZCZ,    8'd3,   8'd230);
      send_command(CMD_S,      8'd5,   8'd250);
      send_command(CMD_ZCX,    8'd199, 8'd0);
      send_command(CMD_READ_X, 8'd130, 8'd0);
      send_command(CMD_SPARE_FIRST, 8'd200, 8'd200);
      send_command(CMD_SWAP,   8'd199, 8'd199);

      // full size, back to back with no idling at all
      settle();
      set_active(256);
      gaps_on = 1'b0;
      send_random(50);
      // idling again, with one pause in the middle until every reply is in
      gaps_on = 1'b1;
      send_random(20);
      settle();
      send_random(20);

      // a single qubit: two-qubit gates can only collide or run out of range
      settle();
      set_active(1);
      send_random(15);

      // all nine bits set: clamped to the full tableau
      settle();
      set_active(511);
      send_random(30);

      // one bit spills into the second word
      settle();
      set_active(65);
      send_random(25);

      // nothing active: every gate and query is out of range
      settle();
      set_active(0);
      send_random(8);

      settle();
      set_active($urandom_range(256, 2));
      send_random(30);

      // drain, then allow for any late reply
      settle();
      repeat (16) @(posedge clock);
      if (fault_count == 0 && replies_due == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // far beyond the slowest correct run, clearing pass included
   initial begin
      #200000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

### files.f
src/ctgu_pkg.sv
src/ctgu_ctrl.sv
src/ctgu_datapath.sv
src/clifford_tableau_gate_update_top.sv
bench/tableau_reply_checker.sv
bench/clifford_tableau_gate_update_top_tb.sv
